// ===== rtl/cce_pkg.sv =====
// Shared constants for the console cursor and attribute engine.
package cce_pkg;

    // Number of raw event classes held in the enable mask.
    localparam int EVENT_CLASSES = 32;
    localparam int EVENT_IDX_W   = (EVENT_CLASSES > 1) ? $clog2(EVENT_CLASSES) : 1;

    // Width of the working value of the shared adder (signed).
    localparam int XW = 11;

    // Request codes.
    localparam logic [3:0] REQ_LEFT   = 4'd0;
    localparam logic [3:0] REQ_RIGHT  = 4'd1;
    localparam logic [3:0] REQ_UP     = 4'd2;
    localparam logic [3:0] REQ_DOWN   = 4'd3;
    localparam logic [3:0] REQ_MODE   = 4'd4;
    localparam logic [3:0] REQ_SGR    = 4'd5;
    localparam logic [3:0] REQ_EV_SET = 4'd6;
    localparam logic [3:0] REQ_EV_CLR = 4'd7;
    localparam logic [3:0] REQ_RESIZE = 4'd8;

    // Mode bit positions.
    localparam int MODE_LINEFEED   = 0;
    localparam int MODE_AUTOSCROLL = 1;
    localparam int MODE_AUTOWRAP   = 2;

    // Scroll directions.
    localparam logic [1:0] SCROLL_NONE = 2'd0;
    localparam logic [1:0] SCROLL_UP   = 2'd1;
    localparam logic [1:0] SCROLL_DOWN = 2'd2;

    // Reset values of the screen state.
    localparam logic [7:0] COL_LIMIT_RST = 8'd79;
    localparam logic [7:0] ROW_LIMIT_RST = 8'd23;

    // Rendition parameters.
    localparam logic [7:0] SGR_RESET     = 8'd0;
    localparam logic [7:0] SGR_BOLD      = 8'd1;
    localparam logic [7:0] SGR_ITALIC    = 8'd3;
    localparam logic [7:0] SGR_UNDERLINE = 8'd4;
    localparam logic [7:0] SGR_REVERSE   = 8'd7;
    localparam logic [7:0] SGR_CONCEAL   = 8'd8;
    localparam logic [7:0] SGR_NO_BOLD   = 8'd22;
    localparam logic [7:0] SGR_NO_ITALIC = 8'd23;
    localparam logic [7:0] SGR_NO_UNDER  = 8'd24;
    localparam logic [7:0] SGR_NO_REV    = 8'd27;
    localparam logic [7:0] SGR_NO_CONC   = 8'd28;
    localparam logic [7:0] SGR_FG_FIRST  = 8'd30;
    localparam logic [7:0] SGR_FG_LAST   = 8'd37;
    localparam logic [7:0] SGR_FG_DEF    = 8'd39;
    localparam logic [7:0] SGR_BG_FIRST  = 8'd40;
    localparam logic [7:0] SGR_BG_LAST   = 8'd47;
    localparam logic [7:0] SGR_BG_DEF    = 8'd49;

    localparam logic [2:0] FG_DEFAULT = 3'd1;
    localparam logic [2:0] BG_DEFAULT = 3'd0;

endpackage

// ===== rtl/console_cursor_attribute_engine_unit.sv =====
// Top level of the console cursor and attribute engine.
//
// Keeps the cursor, screen limits, mode bits, pens, text attributes and the
// raw event enable mask of a text terminal. One request on the input channel
// (in_valid/in_ready) yields exactly one result on the output channel
// (out_valid/out_ready) holding the state after the request.
// Mode, rendition, event, resize and unknown requests go from the accept
// straight to the finish state. Moves run through one shared 11-bit adder
// under a small sequencer: up and down pass through load, vertical and
// excess; left and right first loop in the wrap state once per line wrapped
// (at most 255), or without autowrap go from load to finish. The wrap loop
// adds or subtracts one screen width per cycle. in_ready is high only while
// the sequencer is idle, one request at a time; the next request can be
// accepted in the same cycle that out_valid rises. A finished result waits
// in the output register while out_ready is low; the next request can still
// be accepted then and holds in the finish state until the output register
// frees up. Reset puts the cursor at column 0, row 0, limits at 79 and 23,
// all modes on, pens and attributes at 0 and the event mask clear.
module console_cursor_attribute_engine_unit
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [3:0] req_type,
    input  logic [7:0] move_count,
    input  logic [1:0] mode_select,
    input  logic       mode_value,
    input  logic [7:0] rendition_param,
    input  logic [7:0] event_class,
    input  logic [7:0] new_col_max,
    input  logic [7:0] new_row_max,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] cursor_col,
    output logic [7:0] cursor_row,
    output logic [1:0] scroll_dir,
    output logic [8:0] scroll_lines,
    output logic [2:0] fg_pen,
    output logic [2:0] bg_pen,
    output logic [4:0] attr_flags,
    output logic [2:0] mode_flags,
    output logic       event_enabled
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LOAD   = 3'd1;
    localparam logic [2:0] ST_WRAP   = 3'd2;
    localparam logic [2:0] ST_VERT   = 3'd3;
    localparam logic [2:0] ST_EXCESS = 3'd4;
    localparam logic [2:0] ST_FIN    = 3'd5;

    localparam int XW = cce_pkg::XW;

    // Control and terminal state.
    logic [2:0] state_reg;
    logic [7:0] col_reg;
    logic [7:0] row_reg;
    logic [7:0] col_limit_reg;
    logic [7:0] row_limit_reg;
    logic [2:0] mode_reg;
    logic [2:0] fg_reg;
    logic [2:0] bg_reg;
    logic [4:0] attr_reg;
    logic [cce_pkg::EVENT_CLASSES-1:0] event_mask_reg;
    logic [1:0] scr_dir_reg;
    logic [8:0] scr_lines_reg;
    logic       out_valid_reg;

    // Working registers of the current request.
    logic [3:0]    req_reg;
    logic [7:0]    cnt_reg;
    logic [7:0]    cls_reg;
    logic [XW-1:0] x_reg;
    logic [8:0]    lines_reg;

    // Output register.
    logic [7:0] out_col_reg;
    logic [7:0] out_row_reg;
    logic [1:0] out_dir_reg;
    logic [8:0] out_lines_reg;
    logic [2:0] out_fg_reg;
    logic [2:0] out_bg_reg;
    logic [4:0] out_attr_reg;
    logic [2:0] out_mode_reg;
    logic       out_ev_reg;

    // Shared adder.
    logic [XW-1:0] add_a;
    logic [XW-1:0] add_b;
    logic          add_sub;
    logic [XW-1:0] add_sum;

    logic       accept;
    logic       out_free;
    logic       is_up_dir;
    logic       x_neg;
    logic       x_gt_col;
    logic       x_gt_row;
    logic [8:0] width;
    logic [8:0] sum_sat;
    logic       in_class;
    logic       cls_in_class;
    logic [2:0] sgr_fg;
    logic [2:0] sgr_bg;
    logic [4:0] sgr_attr;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign is_up_dir = (req_reg == cce_pkg::REQ_LEFT) || (req_reg == cce_pkg::REQ_UP);
    assign width     = {1'b0, col_limit_reg} + 9'd1;
    assign x_neg     = x_reg[XW-1];
    assign x_gt_col  = !x_neg && (x_reg > XW'(col_limit_reg));
    assign x_gt_row  = !x_neg && (x_reg > XW'(row_limit_reg));
    assign sum_sat   = (add_sum > XW'(511)) ? 9'h1FF : add_sum[8:0];
    assign in_class     = (32'(event_class) < cce_pkg::EVENT_CLASSES);
    assign cls_in_class = (32'(cls_reg) < cce_pkg::EVENT_CLASSES);

    always_comb
    begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                add_a   = XW'(col_reg);
                add_b   = XW'(cnt_reg);
                add_sub = (req_reg == cce_pkg::REQ_LEFT);
            end
            ST_WRAP:
            begin
                add_a   = x_reg;
                add_b   = XW'(width);
                add_sub = (req_reg == cce_pkg::REQ_RIGHT);
            end
            ST_VERT:
            begin
                add_a   = XW'(row_reg);
                add_b   = XW'(lines_reg);
                add_sub = is_up_dir;
            end
            ST_EXCESS:
            begin
                // Upward overshoot is 0 - r, downward overshoot is r - row limit.
                add_a   = is_up_dir ? '0 : x_reg;
                add_b   = is_up_dir ? x_reg : XW'(row_limit_reg);
                add_sub = 1'b1;
            end
            default:
            begin
                add_a   = '0;
                add_b   = '0;
                add_sub = 1'b0;
            end
        endcase
        add_sum = add_a + (add_sub ? ~add_b : add_b) + XW'(add_sub);
    end

    // Rendition parameter decode.
    always_comb
    begin
        sgr_fg   = fg_reg;
        sgr_bg   = bg_reg;
        sgr_attr = attr_reg;
        priority if (rendition_param == cce_pkg::SGR_RESET)
        begin
            sgr_fg   = cce_pkg::FG_DEFAULT;
            sgr_bg   = cce_pkg::BG_DEFAULT;
            sgr_attr = '0;
        end
        else if (rendition_param == cce_pkg::SGR_BOLD)      sgr_attr[0] = 1'b1;
        else if (rendition_param == cce_pkg::SGR_ITALIC)    sgr_attr[1] = 1'b1;
        else if (rendition_param == cce_pkg::SGR_UNDERLINE) sgr_attr[2] = 1'b1;
        else if (rendition_param == cce_pkg::SGR_REVERSE)   sgr_attr[3] = 1'b1;
        else if (rendition_param == cce_pkg::SGR_CONCEAL)   sgr_attr[4] = 1'b1;
        else if (rendition_param == cce_pkg::SGR_NO_BOLD)   sgr_attr[0] = 1'b0;
        else if (rendition_param == cce_pkg::SGR_NO_ITALIC) sgr_attr[1] = 1'b0;
        else if (rendition_param == cce_pkg::SGR_NO_UNDER)  sgr_attr[2] = 1'b0;
        else if (rendition_param == cce_pkg::SGR_NO_REV)    sgr_attr[3] = 1'b0;
        else if (rendition_param == cce_pkg::SGR_NO_CONC)   sgr_attr[4] = 1'b0;
        else if (rendition_param >= cce_pkg::SGR_FG_FIRST &&
                 rendition_param <= cce_pkg::SGR_FG_LAST)
            sgr_fg = rendition_param[2:0] - cce_pkg::SGR_FG_FIRST[2:0];
        else if (rendition_param == cce_pkg::SGR_FG_DEF)    sgr_fg = cce_pkg::FG_DEFAULT;
        else if (rendition_param >= cce_pkg::SGR_BG_FIRST &&
                 rendition_param <= cce_pkg::SGR_BG_LAST)
            sgr_bg = rendition_param[2:0] - cce_pkg::SGR_BG_FIRST[2:0];
        else if (rendition_param == cce_pkg::SGR_BG_DEF)    sgr_bg = cce_pkg::BG_DEFAULT;
        else
        begin
            // Unknown parameters leave the rendition as it is.
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            col_reg        <= '0;
            row_reg        <= '0;
            col_limit_reg  <= cce_pkg::COL_LIMIT_RST;
            row_limit_reg  <= cce_pkg::ROW_LIMIT_RST;
            mode_reg       <= 3'b111;
            fg_reg         <= '0;
            bg_reg         <= '0;
            attr_reg       <= '0;
            event_mask_reg <= '0;
            scr_dir_reg    <= cce_pkg::SCROLL_NONE;
            scr_lines_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // A result loaded in the finish state keeps out_valid high.
            if (out_valid_reg && out_ready && (state_reg != ST_FIN))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        scr_dir_reg   <= cce_pkg::SCROLL_NONE;
                        scr_lines_reg <= '0;
                        if (req_type == cce_pkg::REQ_LEFT || req_type == cce_pkg::REQ_RIGHT ||
                            req_type == cce_pkg::REQ_UP || req_type == cce_pkg::REQ_DOWN)
                        begin
                            state_reg <= ST_LOAD;
                        end
                        else
                        begin
                            state_reg <= ST_FIN;
                        end
                        case (req_type)
                            cce_pkg::REQ_LEFT, cce_pkg::REQ_RIGHT,
                            cce_pkg::REQ_UP, cce_pkg::REQ_DOWN:
                            begin
                                // Moves are carried out by the sequencer.
                            end
                            cce_pkg::REQ_MODE:
                            begin
                                if (mode_select != 2'd3)
                                begin
                                    mode_reg[mode_select] <= mode_value;
                                end
                            end
                            cce_pkg::REQ_SGR:
                            begin
                                fg_reg   <= sgr_fg;
                                bg_reg   <= sgr_bg;
                                attr_reg <= sgr_attr;
                            end
                            cce_pkg::REQ_EV_SET:
                            begin
                                if (in_class)
                                begin
                                    event_mask_reg[event_class[cce_pkg::EVENT_IDX_W-1:0]]
                                        <= 1'b1;
                                end
                            end
                            cce_pkg::REQ_EV_CLR:
                            begin
                                if (in_class)
                                begin
                                    event_mask_reg[event_class[cce_pkg::EVENT_IDX_W-1:0]]
                                        <= 1'b0;
                                end
                            end
                            cce_pkg::REQ_RESIZE:
                            begin
                                col_limit_reg <= new_col_max;
                                row_limit_reg <= new_row_max;
                                if (col_reg > new_col_max)
                                begin
                                    col_reg <= new_col_max;
                                end
                                if (row_reg > new_row_max)
                                begin
                                    row_reg <= new_row_max;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_LOAD:
                begin
                    if (req_reg == cce_pkg::REQ_UP || req_reg == cce_pkg::REQ_DOWN)
                    begin
                        state_reg <= ST_VERT;
                    end
                    else if (mode_reg[cce_pkg::MODE_AUTOWRAP])
                    begin
                        state_reg <= ST_WRAP;
                    end
                    else
                    begin
                        // Without autowrap the column clamps to the screen.
                        if (add_sum[XW-1])
                        begin
                            col_reg <= '0;
                        end
                        else if (add_sum > XW'(col_limit_reg))
                        begin
                            col_reg <= col_limit_reg;
                        end
                        else
                        begin
                            col_reg <= add_sum[7:0];
                        end
                        state_reg <= ST_FIN;
                    end
                end
                ST_WRAP:
                begin
                    if (!((req_reg == cce_pkg::REQ_LEFT) ? x_neg : x_gt_col))
                    begin
                        col_reg   <= x_reg[7:0];
                        state_reg <= ST_VERT;
                    end
                end
                ST_VERT:
                begin
                    state_reg <= ST_EXCESS;
                end
                ST_EXCESS:
                begin
                    if (is_up_dir)
                    begin
                        if (x_neg)
                        begin
                            row_reg <= '0;
                            if (mode_reg[cce_pkg::MODE_AUTOSCROLL])
                            begin
                                scr_dir_reg   <= cce_pkg::SCROLL_DOWN;
                                scr_lines_reg <= sum_sat;
                            end
                        end
                        else
                        begin
                            row_reg <= x_reg[7:0];
                        end
                    end
                    else
                    begin
                        if (x_gt_row)
                        begin
                            row_reg <= row_limit_reg;
                            if (mode_reg[cce_pkg::MODE_AUTOSCROLL])
                            begin
                                scr_dir_reg   <= cce_pkg::SCROLL_UP;
                                scr_lines_reg <= sum_sat;
                            end
                        end
                        else
                        begin
                            row_reg <= x_reg[7:0];
                        end
                    end
                    state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Working and output registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_type;
            cnt_reg <= move_count;
            cls_reg <= event_class;
        end
        case (state_reg)
            ST_LOAD:
            begin
                x_reg     <= add_sum;
                lines_reg <= (req_reg == cce_pkg::REQ_UP || req_reg == cce_pkg::REQ_DOWN)
                             ? {1'b0, cnt_reg} : 9'd0;
            end
            ST_WRAP:
            begin
                if ((req_reg == cce_pkg::REQ_LEFT) ? x_neg : x_gt_col)
                begin
                    x_reg     <= add_sum;
                    lines_reg <= lines_reg + 9'd1;
                end
            end
            ST_VERT:
            begin
                x_reg <= add_sum;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_col_reg   <= col_reg;
                    out_row_reg   <= row_reg;
                    out_dir_reg   <= scr_dir_reg;
                    out_lines_reg <= scr_lines_reg;
                    out_fg_reg    <= fg_reg;
                    out_bg_reg    <= bg_reg;
                    out_attr_reg  <= attr_reg;
                    out_mode_reg  <= mode_reg;
                    out_ev_reg    <= cls_in_class &&
                                     event_mask_reg[cls_reg[cce_pkg::EVENT_IDX_W-1:0]];
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign cursor_col    = out_col_reg;
    assign cursor_row    = out_row_reg;
    assign scroll_dir    = out_dir_reg;
    assign scroll_lines  = out_lines_reg;
    assign fg_pen        = out_fg_reg;
    assign bg_pen        = out_bg_reg;
    assign attr_flags    = out_attr_reg;
    assign mode_flags    = out_mode_reg;
    assign event_enabled = out_ev_reg;

    // The cursor stays inside the screen whenever no request is in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (col_reg <= col_limit_reg && row_reg <= row_limit_reg))
        else $error("cursor outside screen limits while idle");

    // A result without a scroll reports no scroll lines, and a scroll reports some.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_dir_reg == cce_pkg::SCROLL_NONE) == (out_lines_reg == 9'd0)))
        else $error("scroll direction and line count disagree");

    // Scrolling only comes from a move request.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && scr_dir_reg != cce_pkg::SCROLL_NONE)
        |-> (req_reg == cce_pkg::REQ_LEFT || req_reg == cce_pkg::REQ_RIGHT ||
             req_reg == cce_pkg::REQ_UP || req_reg == cce_pkg::REQ_DOWN))
        else $error("scroll reported for a non-move request");

    // The output register is never loaded over a result that was not taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> out_valid_reg && $stable(out_col_reg)
                                          && $stable(out_row_reg))
        else $error("pending result overwritten");

endmodule

// ===== tb/tb_console_cursor_attribute_engine_unit.sv =====
// Self-checking testbench for the console cursor and attribute engine.
`timescale 1ns / 1ps

module tb_console_cursor_attribute_engine_unit;

    localparam int RANDOM_REQUESTS = 1500;
    localparam int DRAIN_CYCLES    = 300;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int REPORT_LIMIT    = 10;

    localparam logic [3:0] REQ_UNUSED_FIRST = 4'd9;
    localparam logic [3:0] REQ_UNUSED_LAST  = 4'd15;

    localparam int ATTR_BOLD      = 0;
    localparam int ATTR_ITALIC    = 1;
    localparam int ATTR_UNDERLINE = 2;
    localparam int ATTR_REVERSE   = 3;
    localparam int ATTR_CONCEAL   = 4;

    localparam logic [7:0] SGR_UNKNOWN_BLINK = 8'd25;
    localparam logic [7:0] SGR_UNKNOWN_TOP   = 8'd255;

    localparam logic [7:0] SGR_POOL [13] = '{
        cce_pkg::SGR_RESET, cce_pkg::SGR_BOLD, cce_pkg::SGR_ITALIC,
        cce_pkg::SGR_UNDERLINE, cce_pkg::SGR_REVERSE, cce_pkg::SGR_CONCEAL,
        cce_pkg::SGR_NO_BOLD, cce_pkg::SGR_NO_ITALIC, cce_pkg::SGR_NO_UNDER,
        cce_pkg::SGR_NO_REV, cce_pkg::SGR_NO_CONC,
        cce_pkg::SGR_FG_DEF, cce_pkg::SGR_BG_DEF
    };

    typedef struct {
        logic [3:0] kind;
        logic [7:0] count;
        logic [1:0] msel;
        logic       mval;
        logic [7:0] sgr;
        logic [7:0] ev_class;
        logic [7:0] ncol;
        logic [7:0] nrow;
    } term_req_t;

    typedef struct {
        logic [7:0] col;
        logic [7:0] row;
        logic [1:0] dir;
        logic [8:0] lines;
        logic [2:0] fg;
        logic [2:0] bg;
        logic [4:0] attrs;
        logic [2:0] modes;
        logic       ev;
    } term_view_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [3:0] req_type;
    logic [7:0] move_count;
    logic [1:0] mode_select;
    logic       mode_value;
    logic [7:0] rendition_param;
    logic [7:0] event_class;
    logic [7:0] new_col_max;
    logic [7:0] new_row_max;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] cursor_col;
    logic [7:0] cursor_row;
    logic [1:0] scroll_dir;
    logic [8:0] scroll_lines;
    logic [2:0] fg_pen;
    logic [2:0] bg_pen;
    logic [4:0] attr_flags;
    logic [2:0] mode_flags;
    logic       event_enabled;

    // Terminal state as the testbench predicts it.
    int                                cur_col  = 0;
    int                                cur_row  = 0;
    int                                lim_col  = int'(cce_pkg::COL_LIMIT_RST);
    int                                lim_row  = int'(cce_pkg::ROW_LIMIT_RST);
    logic [2:0]                        modes    = 3'b111;
    logic [2:0]                        pen_fg   = 3'd0;
    logic [2:0]                        pen_bg   = 3'd0;
    logic [4:0]                        attrs    = 5'd0;
    logic [cce_pkg::EVENT_CLASSES-1:0] ev_mask  = '0;

    term_view_t pending_views[$];
    int         failures        = 0;
    int         results_seen    = 0;
    int         hold_off_cycles = 0;
    bit         stalls_on       = 1'b1;
    bit         sender_gaps_on  = 1'b1;

    console_cursor_attribute_engine_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .move_count     (move_count),
        .mode_select    (mode_select),
        .mode_value     (mode_value),
        .rendition_param(rendition_param),
        .event_class    (event_class),
        .new_col_max    (new_col_max),
        .new_row_max    (new_row_max),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .cursor_col     (cursor_col),
        .cursor_row     (cursor_row),
        .scroll_dir     (scroll_dir),
        .scroll_lines   (scroll_lines),
        .fg_pen         (fg_pen),
        .bg_pen         (bg_pen),
        .attr_flags     (attr_flags),
        .mode_flags     (mode_flags),
        .event_enabled  (event_enabled)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #15_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Applies one request to the predicted state and returns the view after it.
    function automatic term_view_t terminal_step(term_req_t r);
        term_view_t v;
        int         cnt;
        int         x;
        int         w;
        int         wraps;
        int         row;
        int         slines;
        logic [1:0] sdir;
        bit         class_ok;

        cnt      = int'(r.count);
        row      = cur_row;
        sdir     = cce_pkg::SCROLL_NONE;
        slines   = 0;
        class_ok = (r.ev_class < cce_pkg::EVENT_CLASSES);

        case (r.kind)
            cce_pkg::REQ_LEFT, cce_pkg::REQ_RIGHT:
            begin
                x = (r.kind == cce_pkg::REQ_LEFT) ? cur_col - cnt : cur_col + cnt;
                w = lim_col + 1;
                if (!modes[cce_pkg::MODE_AUTOWRAP])
                begin
                    if (x < 0)
                        x = 0;
                    else if (x > lim_col)
                        x = lim_col;
                end
                else if (x < 0)
                begin
                    wraps = (-x + w - 1) / w;
                    x     = x + wraps * w;
                    row   = cur_row - wraps;
                end
                else if (x > lim_col)
                begin
                    wraps = x / w;
                    x     = x - wraps * w;
                    row   = cur_row + wraps;
                end
                cur_col = x;
            end
            cce_pkg::REQ_UP:   row = cur_row - cnt;
            cce_pkg::REQ_DOWN: row = cur_row + cnt;
            cce_pkg::REQ_MODE:
            begin
                if (r.msel <= cce_pkg::MODE_AUTOWRAP)
                    modes[r.msel] = r.mval;
            end
            cce_pkg::REQ_SGR:
            begin
                case (r.sgr)
                    cce_pkg::SGR_RESET:
                    begin
                        pen_fg = cce_pkg::FG_DEFAULT;
                        pen_bg = cce_pkg::BG_DEFAULT;
                        attrs  = '0;
                    end
                    cce_pkg::SGR_BOLD:      attrs[ATTR_BOLD]      = 1'b1;
                    cce_pkg::SGR_ITALIC:    attrs[ATTR_ITALIC]    = 1'b1;
                    cce_pkg::SGR_UNDERLINE: attrs[ATTR_UNDERLINE] = 1'b1;
                    cce_pkg::SGR_REVERSE:   attrs[ATTR_REVERSE]   = 1'b1;
                    cce_pkg::SGR_CONCEAL:   attrs[ATTR_CONCEAL]   = 1'b1;
                    cce_pkg::SGR_NO_BOLD:   attrs[ATTR_BOLD]      = 1'b0;
                    cce_pkg::SGR_NO_ITALIC: attrs[ATTR_ITALIC]    = 1'b0;
                    cce_pkg::SGR_NO_UNDER:  attrs[ATTR_UNDERLINE] = 1'b0;
                    cce_pkg::SGR_NO_REV:    attrs[ATTR_REVERSE]   = 1'b0;
                    cce_pkg::SGR_NO_CONC:   attrs[ATTR_CONCEAL]   = 1'b0;
                    cce_pkg::SGR_FG_DEF:    pen_fg = cce_pkg::FG_DEFAULT;
                    cce_pkg::SGR_BG_DEF:    pen_bg = cce_pkg::BG_DEFAULT;
                    default:
                    begin
                        if (r.sgr >= cce_pkg::SGR_FG_FIRST && r.sgr <= cce_pkg::SGR_FG_LAST)
                            pen_fg = 3'(r.sgr - cce_pkg::SGR_FG_FIRST);
                        else if (r.sgr >= cce_pkg::SGR_BG_FIRST &&
                                 r.sgr <= cce_pkg::SGR_BG_LAST)
                            pen_bg = 3'(r.sgr - cce_pkg::SGR_BG_FIRST);
                    end
                endcase
            end
            cce_pkg::REQ_EV_SET:
            begin
                if (class_ok)
                    ev_mask[r.ev_class[cce_pkg::EVENT_IDX_W-1:0]] = 1'b1;
            end
            cce_pkg::REQ_EV_CLR:
            begin
                if (class_ok)
                    ev_mask[r.ev_class[cce_pkg::EVENT_IDX_W-1:0]] = 1'b0;
            end
            cce_pkg::REQ_RESIZE:
            begin
                lim_col = int'(r.ncol);
                lim_row = int'(r.nrow);
                if (cur_col > lim_col)
                    cur_col = lim_col;
                if (row > lim_row)
                    row = lim_row;
            end
            default: ;
        endcase

        // A row that leaves the screen always clamps and, with autoscroll on, also scrolls.
        if (row < 0)
        begin
            if (modes[cce_pkg::MODE_AUTOSCROLL])
            begin
                sdir   = cce_pkg::SCROLL_DOWN;
                slines = -row;
            end
            row = 0;
        end
        else if (row > lim_row)
        begin
            if (modes[cce_pkg::MODE_AUTOSCROLL])
            begin
                sdir   = cce_pkg::SCROLL_UP;
                slines = row - lim_row;
            end
            row = lim_row;
        end
        cur_row = row;

        v.col   = 8'(cur_col);
        v.row   = 8'(cur_row);
        v.dir   = sdir;
        v.lines = (slines > 511) ? 9'd511 : 9'(slines);
        v.fg    = pen_fg;
        v.bg    = pen_bg;
        v.attrs = attrs;
        v.modes = modes;
        v.ev    = class_ok ? ev_mask[r.ev_class[cce_pkg::EVENT_IDX_W-1:0]] : 1'b0;
        return v;
    endfunction

    function automatic int gap_cycles();
        int pick;

        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(12, 45);
    endfunction

    function automatic term_req_t noisy_request(logic [3:0] kind);
        term_req_t r;

        r.kind     = kind;
        r.count    = 8'($urandom);
        r.msel     = 2'($urandom);
        r.mval     = 1'($urandom);
        r.sgr      = 8'($urandom);
        r.ev_class = 8'($urandom);
        r.ncol     = 8'($urandom);
        r.nrow     = 8'($urandom);
        return r;
    endfunction

    function automatic term_req_t random_request();
        term_req_t r;
        int        pick;

        r    = noisy_request(cce_pkg::REQ_LEFT);
        pick = $urandom_range(0, 99);
        if (pick < 15)      r.kind = cce_pkg::REQ_LEFT;
        else if (pick < 30) r.kind = cce_pkg::REQ_RIGHT;
        else if (pick < 40) r.kind = cce_pkg::REQ_UP;
        else if (pick < 50) r.kind = cce_pkg::REQ_DOWN;
        else if (pick < 62) r.kind = cce_pkg::REQ_MODE;
        else if (pick < 77) r.kind = cce_pkg::REQ_SGR;
        else if (pick < 85) r.kind = cce_pkg::REQ_EV_SET;
        else if (pick < 91) r.kind = cce_pkg::REQ_EV_CLR;
        else if (pick < 97) r.kind = cce_pkg::REQ_RESIZE;
        else                r.kind = 4'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST));

        if ($urandom_range(0, 3) != 0)
            r.count = 8'($urandom_range(0, 24));

        pick = $urandom_range(0, 9);
        if (pick < 2)
            r.sgr = 8'($urandom_range(cce_pkg::SGR_FG_FIRST, cce_pkg::SGR_FG_LAST));
        else if (pick < 4)
            r.sgr = 8'($urandom_range(cce_pkg::SGR_BG_FIRST, cce_pkg::SGR_BG_LAST));
        else if (pick < 8)
            r.sgr = SGR_POOL[$urandom_range(0, $size(SGR_POOL) - 1)];

        if ($urandom_range(0, 9) < 8)
            r.ev_class = 8'($urandom_range(0, cce_pkg::EVENT_CLASSES - 1));

        // Mostly ordinary screens; the odd fully random size hits the extremes.
        if ($urandom_range(0, 19) != 0)
        begin
            r.ncol = 8'($urandom_range(4, 160));
            r.nrow = 8'($urandom_range(2, 60));
        end
        return r;
    endfunction

    task automatic note_failure(string msg);
        failures++;
        if (failures <= REPORT_LIMIT)
            $display("%s", msg);
    endtask

    task automatic compare_field(string name, int want, int got);
        if (want != got)
            note_failure($sformatf("result %0d: %s expected %0d got %0d",
                                   results_seen, name, want, got));
    endtask

    // Offers one request, waits for it to be taken, then idles at random.
    task automatic send_request(term_req_t r);
        int gap;

        @(negedge clk);
        in_valid        <= 1'b1;
        req_type        <= r.kind;
        move_count      <= r.count;
        mode_select     <= r.msel;
        mode_value      <= r.mval;
        rendition_param <= r.sgr;
        event_class     <= r.ev_class;
        new_col_max     <= r.ncol;
        new_row_max     <= r.nrow;
        do
            @(posedge clk);
        while (!in_ready);
        pending_views.push_back(terminal_step(r));

        gap = sender_gaps_on ? gap_cycles() : 0;
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        term_view_t want;

        if (rst_n && out_valid && out_ready)
        begin
            if (pending_views.size() == 0)
            begin
                note_failure($sformatf("result %0d arrived with no request pending",
                                       results_seen));
            end
            else
            begin
                want = pending_views.pop_front();
                compare_field("cursor_col", int'(want.col), int'(cursor_col));
                compare_field("cursor_row", int'(want.row), int'(cursor_row));
                compare_field("scroll_dir", int'(want.dir), int'(scroll_dir));
                compare_field("scroll_lines", int'(want.lines), int'(scroll_lines));
                compare_field("fg_pen", int'(want.fg), int'(fg_pen));
                compare_field("bg_pen", int'(want.bg), int'(bg_pen));
                compare_field("attr_flags", int'(want.attrs), int'(attr_flags));
                compare_field("mode_flags", int'(want.modes), int'(mode_flags));
                compare_field("event_enabled", int'(want.ev), int'(event_enabled));
            end
            results_seen++;
        end
    end

    // Result side: random stalls, or one long hold-off when a test asks for it.
    initial
    begin : ready_driver
        int stall;

        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles != 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_off_cycles) @(negedge clk);
                hold_off_cycles = 0;
                out_ready <= 1'b1;
            end
            else
            begin
                stall = stalls_on ? gap_cycles() : 0;
                if (stall == 0)
                begin
                    out_ready <= 1'b1;
                end
                else
                begin
                    out_ready <= 1'b0;
                    repeat (stall - 1) @(negedge clk);
                end
            end
        end
    end

    task automatic test_unknown_request();
        term_req_t r;

        r = noisy_request(REQ_UNUSED_LAST);
        r.count = 8'hff;
        r.sgr   = 8'hff;
        r.ncol  = 8'hff;
        r.nrow  = 8'hff;
        send_request(r);
    endtask

    // All modes on after reset: the horizontal moves wrap and the vertical moves scroll.
    task automatic test_cursor_moves();
        term_req_t r;

        r = noisy_request(cce_pkg::REQ_LEFT);  r.count = 8'hff; send_request(r);
        r = noisy_request(cce_pkg::REQ_RIGHT); r.count = 8'hff; send_request(r);
        r = noisy_request(cce_pkg::REQ_DOWN);  r.count = 8'hff; send_request(r);
        r = noisy_request(cce_pkg::REQ_UP);    r.count = 8'hff; send_request(r);
    endtask

    task automatic test_mode_bits();
        term_req_t r;

        r = noisy_request(cce_pkg::REQ_MODE);
        r.msel = 2'(cce_pkg::MODE_AUTOWRAP);   r.mval = 1'b0; send_request(r);
        r = noisy_request(cce_pkg::REQ_MODE);
        r.msel = 2'(cce_pkg::MODE_AUTOSCROLL); r.mval = 1'b0; send_request(r);
        r = noisy_request(cce_pkg::REQ_MODE);
        r.msel = 2'(cce_pkg::MODE_LINEFEED);   r.mval = 1'b0; send_request(r);
        // Selector past the last mode must leave the bits alone.
        r = noisy_request(cce_pkg::REQ_MODE);
        r.msel = 2'b11;                        r.mval = 1'b1; send_request(r);
        r = noisy_request(cce_pkg::REQ_LEFT); r.count = 8'hff; send_request(r);
        r = noisy_request(cce_pkg::REQ_DOWN); r.count = 8'hff; send_request(r);
        r = noisy_request(cce_pkg::REQ_MODE);
        r.msel = 2'(cce_pkg::MODE_LINEFEED);   r.mval = 1'b1; send_request(r);
        r = noisy_request(cce_pkg::REQ_MODE);
        r.msel = 2'(cce_pkg::MODE_AUTOSCROLL); r.mval = 1'b1; send_request(r);
        r = noisy_request(cce_pkg::REQ_MODE);
        r.msel = 2'(cce_pkg::MODE_AUTOWRAP);   r.mval = 1'b1; send_request(r);
    endtask

    task automatic test_rendition();
        term_req_t r;

        r = noisy_request(cce_pkg::REQ_SGR); r.sgr = cce_pkg::SGR_RESET;   send_request(r);
        r = noisy_request(cce_pkg::REQ_SGR); r.sgr = cce_pkg::SGR_FG_LAST; send_request(r);
        r = noisy_request(cce_pkg::REQ_SGR); r.sgr = cce_pkg::SGR_BG_LAST; send_request(r);
        r = noisy_request(cce_pkg::REQ_SGR); r.sgr = SGR_UNKNOWN_BLINK;    send_request(r);
        r = noisy_request(cce_pkg::REQ_SGR); r.sgr = SGR_UNKNOWN_TOP;      send_request(r);
    endtask

    task automatic test_event_mask();
        term_req_t r;

        r = noisy_request(cce_pkg::REQ_EV_SET);
        r.ev_class = 8'(cce_pkg::EVENT_CLASSES - 1); send_request(r);
        r = noisy_request(cce_pkg::REQ_EV_SET);
        r.ev_class = 8'(cce_pkg::EVENT_CLASSES);     send_request(r);
        r = noisy_request(cce_pkg::REQ_EV_CLR);
        r.ev_class = 8'(cce_pkg::EVENT_CLASSES - 1); send_request(r);
    endtask

    // One-cell screen gives the longest wrap loop; the widest screen the shortest.
    task automatic test_resize();
        term_req_t r;

        r = noisy_request(cce_pkg::REQ_RESIZE); r.ncol = 8'h00; r.nrow = 8'h00; send_request(r);
        r = noisy_request(cce_pkg::REQ_RIGHT);  r.count = 8'hff; send_request(r);
        r = noisy_request(cce_pkg::REQ_RESIZE); r.ncol = 8'hff; r.nrow = 8'hff; send_request(r);
        r = noisy_request(cce_pkg::REQ_LEFT);   r.count = 8'hff; send_request(r);
    endtask

    // Every fourth block of requests runs with no idling on either side.
    task automatic test_random_traffic();
        term_req_t r;
        int        counted;

        counted = 0;
        while (counted < RANDOM_REQUESTS)
        begin
            stalls_on      = ((counted / 100) % 4 != 3);
            sender_gaps_on = stalls_on;
            r = random_request();
            send_request(r);
            if (r.kind <= cce_pkg::REQ_RESIZE)
                counted++;
        end
        stalls_on      = 1'b1;
        sender_gaps_on = 1'b1;
    endtask

    // The result side holds off long enough for the block to fill and stall
    // its input while requests keep coming back to back.
    task automatic test_output_hold_off();
        term_req_t r;

        hold_off_cycles = HOLD_OFF_CYCLES;
        sender_gaps_on  = 1'b0;
        repeat (10)
        begin
            r = random_request();
            send_request(r);
        end
        sender_gaps_on = 1'b1;
    endtask

    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        req_type        = '0;
        move_count      = '0;
        mode_select     = '0;
        mode_value      = 1'b0;
        rendition_param = '0;
        event_class     = '0;
        new_col_max     = '0;
        new_row_max     = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_unknown_request();
        test_cursor_moves();
        test_mode_bits();
        test_rendition();
        test_event_mask();
        test_resize();
        test_output_hold_off();
        test_random_traffic();
        test_output_hold_off();

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_views.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
